>>> rtl/sp5_pkg.sv
// Package for the quintic sine pipeline: fixed-point formats, constants and
// the record passed from range reduction to polynomial evaluation.
// No dependencies.
package sp5_pkg;

    // Port formats
    localparam int ANGLE_FRAC_BITS = 20;
    localparam int OUT_FRAC_BITS   = 30;
    localparam int ANGLE_W         = 32;
    localparam int OUT_W           = 32;

    // Internal formats: reduction in Q.44, polynomial in Q.29
    localparam int WORK_BITS = 29;
    localparam int RED_BITS  = 44;

    // pi truncated to 44 fraction bits
    localparam int             PI_W   = 46;
    localparam logic [PI_W-1:0] PI_Q44 = 46'h3243F6A8885A;

    // Magnitude shifted to Q.44
    localparam int AXS_W = ANGLE_W + RED_BITS - ANGLE_FRAC_BITS;

    // Reciprocal of pi for the quotient estimate: k_est = (|x| * RECIP) >> RECIP_SH.
    // The estimate is never above the true quotient and at most one below.
    localparam int         RECIP_SH   = ANGLE_W;
    localparam logic [127:0] RECIP_WIDE =
        (128'd1 << (RECIP_SH + RED_BITS - ANGLE_FRAC_BITS)) / 128'(PI_Q44);
    localparam int         RECIP_W    = $clog2(RECIP_WIDE + 128'd1);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_WIDE);

    // Largest quotient, plus room for the correction step
    localparam logic [127:0] K_MAX =
        ((128'd1 << (ANGLE_W - 1)) << (RED_BITS - ANGLE_FRAC_BITS)) / 128'(PI_Q44);
    localparam int K_W = $clog2(K_MAX + 128'd2);

    // Q.44 -> Q.29 rounding of the reduced magnitude
    localparam int           RED_SH   = RED_BITS - WORK_BITS;
    localparam logic [PI_W:0] RED_HALF = (PI_W + 1)'(1) << (RED_SH - 1);

    // Polynomial argument; beyond T_LIMIT (5.0) the result saturates
    localparam int            T_W     = 32;
    localparam logic [T_W-1:0] T_LIMIT = T_W'(5) << WORK_BITS;
    localparam int            TL_W    = ANGLE_W + WORK_BITS - ANGLE_FRAC_BITS;

    // Coefficients in Q.29
    localparam int                  A_W    = 23;
    localparam int                  B_W    = 28;
    localparam int                  C_W    = 31;
    localparam logic signed [A_W-1:0] COEF_A = 23'sd3947326;
    localparam logic signed [B_W-1:0] COEF_B = -28'sd88738917;
    localparam logic signed [C_W-1:0] COEF_C = 31'sd536705548;

    // Half an LSB for the Q.29 rounding steps
    localparam longint WORK_HALF = longint'(1) << (WORK_BITS - 1);

    // Polynomial widths
    localparam int SQ_W    = 2 * T_W;
    localparam int T2_W    = SQ_W - WORK_BITS;
    localparam int PA_W    = T2_W + 1 + A_W;
    localparam int INNER_W = 30;
    localparam int P2_W    = T2_W + 1 + INNER_W;
    localparam int MID_W   = P2_W - WORK_BITS + 2;
    localparam int P3_W    = T_W + 1 + MID_W;
    localparam int POS_W   = P3_W - WORK_BITS;

    // Output conversion
    localparam int     SH_L    = (OUT_FRAC_BITS >= WORK_BITS) ? OUT_FRAC_BITS - WORK_BITS : 0;
    localparam int     SH_R    = (OUT_FRAC_BITS < WORK_BITS) ? WORK_BITS - OUT_FRAC_BITS : 1;
    localparam int     MAG_W   = POS_W + SH_L + 1;
    localparam longint ONE_OUT = longint'(1) << OUT_FRAC_BITS;

    // Reduced argument handed to the polynomial
    typedef struct packed {
        logic [T_W-1:0] t;    // magnitude, Q.29, below T_LIMIT
        logic           sat;  // result is +-1.0 regardless of t
        logic           neg;  // final sign
    } red_t;

endpackage

>>> rtl/sine_poly5_range_reduced.sv
// Top level of the quintic sine pipeline: stream ports and stall control.
// Depends on sp5_pkg, sp5_reduce and sp5_poly.
//
// Approximate sine of a signed Q11.20 angle, returned as signed Q1.30 within
// +-1.0. With tuser low the angle is first reduced by the nearest multiple of
// pi (ties away from zero); with tuser high the odd quintic is applied to the
// angle directly, which is accurate on [-pi/2, pi/2] and saturates for
// |angle| >= 5.0. One request is taken every cycle while the output is not
// stalled; each request passes 5 stages of reduction and 9 of polynomial and
// output formatting, a depth set by the chain of multiplications, each
// followed by its own register. A low m_tready with a result waiting holds the
// whole pipeline and s_tready drops in the same cycle.
module sine_poly5_range_reduced (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] angle
    input  logic [0:0]  s_tuser,   // [0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] sine_value
);
    import sp5_pkg::*;

    logic                 adv;
    logic                 red_valid;
    red_t                 red;
    logic                 out_valid;
    logic [OUT_W-1:0]     sine;

    // Pipeline moves unless a result waits at the output and m_tready is low
    assign adv      = ~out_valid | m_tready;
    assign s_tready = adv;

    sp5_reduce u_reduce (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s_tvalid),
        .angle     ($signed(s_tdata[ANGLE_W-1:0])),
        .mode      (s_tuser[0]),
        .out_valid (red_valid),
        .red       (red)
    );

    sp5_poly u_poly (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (red_valid),
        .red       (red),
        .out_valid (out_valid),
        .sine      (sine)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = sine;

endmodule

>>> rtl/sp5_reduce.sv
// Range reduction by pi: magnitude, quotient estimate, remainder, fold.
// Five register stages. Depends on sp5_pkg.
module sp5_reduce (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            adv,
    input  logic                            in_valid,
    input  logic signed [sp5_pkg::ANGLE_W-1:0] angle,
    input  logic                            mode,
    output logic                            out_valid,
    output sp5_pkg::red_t                   red
);
    import sp5_pkg::*;

    localparam int PROD_W = ANGLE_W + RECIP_W;
    localparam int KPI_W  = K_W + PI_W;

    // Stage registers
    logic                  v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic [ANGLE_W-1:0]    ax1_reg, ax2_reg, ax3_reg, ax4_reg;
    logic                  neg1_reg, neg2_reg, neg3_reg, neg4_reg;
    logic                  lim1_reg, lim2_reg, lim3_reg, lim4_reg;
    logic [PROD_W-1:0]     prod2_reg;
    logic [K_W-1:0]        kest3_reg;
    logic [AXS_W-1:0]      axs3_reg, kpi3_reg;
    logic [PI_W-1:0]       rem4_reg;
    logic                  kodd4_reg;
    red_t                  red5_reg;

    logic [ANGLE_W-1:0]    ax1_next;
    logic [PROD_W-1:0]     prod2_next;
    logic [K_W-1:0]        kest3_next;
    logic [KPI_W-1:0]      kpi_full;
    logic [AXS_W-1:0]      axs3_next;
    logic [AXS_W:0]        diff_sub;
    logic [AXS_W-1:0]      rem_raw;
    logic                  bump;
    logic [PI_W-1:0]       rem4_next;
    logic                  fold;
    logic [PI_W-1:0]       rmag;
    logic [PI_W:0]         t_round;
    logic [TL_W-1:0]       t_lim;
    logic                  sat_lim;
    red_t                  red5_next;

    // Stage 1: magnitude of the angle (-2^31 keeps magnitude 2^31)
    assign ax1_next = angle[ANGLE_W-1] ? (~angle + ANGLE_W'(1)) : angle;

    // Stage 2: quotient estimate product
    assign prod2_next = PROD_W'(ax1_reg) * PROD_W'(RECIP);

    // Stage 3: k_est * pi against the Q.44 magnitude
    assign kest3_next = K_W'(prod2_reg >> RECIP_SH);
    assign kpi_full   = KPI_W'(kest3_next) * KPI_W'(PI_Q44);
    assign axs3_next  = AXS_W'(ax2_reg) << (RED_BITS - ANGLE_FRAC_BITS);

    // Stage 4: remainder, with one correction step when k_est was one short
    assign rem_raw   = axs3_reg - kpi3_reg;
    assign diff_sub  = {1'b0, axs3_reg} - {1'b0, kpi3_reg} - (AXS_W + 1)'(PI_Q44);
    assign bump      = ~diff_sub[AXS_W];
    assign rem4_next = bump ? diff_sub[PI_W-1:0] : rem_raw[PI_W-1:0];

    // Stage 5: round-to-nearest fold, sign, and conversion to Q.29; in direct mode the 5.0 saturation check
    assign fold    = {rem4_reg, 1'b0} >= {1'b0, PI_Q44};
    assign rmag    = fold ? (PI_Q44 - rem4_reg) : rem4_reg;
    assign t_round = ({1'b0, rmag} + RED_HALF) >> RED_SH;
    assign t_lim   = TL_W'(ax4_reg) << (WORK_BITS - ANGLE_FRAC_BITS);
    assign sat_lim = t_lim >= TL_W'(T_LIMIT);

    always_comb
    begin
        if (lim4_reg)
        begin
            red5_next.t   = sat_lim ? '0 : T_W'(t_lim);
            red5_next.sat = sat_lim;
            red5_next.neg = neg4_reg;
        end
        else
        begin
            red5_next.t   = T_W'(t_round);
            red5_next.sat = 1'b0;
            // a fold steps k up by one and negates r; the two flips cancel
            red5_next.neg = neg4_reg ^ kodd4_reg;
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ax1_reg   <= ax1_next;
            neg1_reg  <= angle[ANGLE_W-1];
            lim1_reg  <= mode;

            prod2_reg <= prod2_next;
            ax2_reg   <= ax1_reg;
            neg2_reg  <= neg1_reg;
            lim2_reg  <= lim1_reg;

            kest3_reg <= kest3_next;
            kpi3_reg  <= AXS_W'(kpi_full);
            axs3_reg  <= axs3_next;
            ax3_reg   <= ax2_reg;
            neg3_reg  <= neg2_reg;
            lim3_reg  <= lim2_reg;

            rem4_reg  <= rem4_next;
            kodd4_reg <= kest3_reg[0] ^ bump;
            ax4_reg   <= ax3_reg;
            neg4_reg  <= neg3_reg;
            lim4_reg  <= lim3_reg;

            red5_reg  <= red5_next;
        end
    end

    assign out_valid = v5_reg;
    assign red       = red5_reg;

endmodule

>>> rtl/sp5_poly.sv
// Odd quintic evaluation t*(C + t2*(B + A*t2)) in Q.29, output scaling,
// saturation and sign. Nine register stages. Depends on sp5_pkg.
module sp5_poly (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  logic                         in_valid,
    input  sp5_pkg::red_t                red,
    output logic                         out_valid,
    output logic [sp5_pkg::OUT_W-1:0]    sine
);
    import sp5_pkg::*;

    // Valid bits and carried sign/saturation per stage
    logic [8:0]              v_reg;
    logic [7:0]              sat_reg;
    logic [7:0]              neg_reg;

    logic [T_W-1:0]          t1_reg, t2s_reg, t3_reg, t4_reg, t5_reg;
    logic [SQ_W-1:0]         sq1_reg;
    logic [T2_W-1:0]         t2_2_reg, t2_3_reg, t2_4_reg;
    logic signed [PA_W-1:0]  pa3_reg;
    logic signed [INNER_W-1:0] inner4_reg;
    logic signed [P2_W-1:0]  p2_5_reg;
    logic signed [MID_W-1:0] mid6_reg;
    logic [T_W-1:0]          t6_reg;
    logic signed [P3_W-1:0]  p3_7_reg;
    logic [POS_W-1:0]        pos8_reg;
    logic [OUT_W-1:0]        sine_reg;

    logic [SQ_W:0]           sq_rnd;
    logic signed [PA_W:0]    pa_rnd;
    logic signed [PA_W:0]    pa_sh;
    logic signed [INNER_W-1:0] inner_next;
    logic signed [P2_W:0]    p2_rnd;
    logic signed [P2_W:0]    p2_sh;
    logic signed [MID_W-1:0] mid_next;
    logic signed [P3_W:0]    p3_rnd;
    logic signed [P3_W:0]    p3_sh;
    logic [POS_W-1:0]        pos_next;
    logic [MAG_W-1:0]        mag_wide;
    logic [OUT_W-1:0]        mag;
    logic [OUT_W-1:0]        sine_next;

    // Stage 2: t2 = round(t*t / 2^29)
    assign sq_rnd = {1'b0, sq1_reg} + (SQ_W + 1)'(WORK_HALF);

    // Stage 4: inner = B + round(A*t2 / 2^29), half away from zero
    assign pa_rnd = (PA_W + 1)'(pa3_reg)
                  + (pa3_reg[PA_W-1] ? (PA_W + 1)'(WORK_HALF - 1) : (PA_W + 1)'(WORK_HALF));
    assign pa_sh      = pa_rnd >>> WORK_BITS;
    assign inner_next = INNER_W'(COEF_B) + INNER_W'(pa_sh);

    // Stage 6: mid = C + round(t2*inner / 2^29)
    assign p2_rnd = (P2_W + 1)'(p2_5_reg)
                  + (p2_5_reg[P2_W-1] ? (P2_W + 1)'(WORK_HALF - 1) : (P2_W + 1)'(WORK_HALF));
    assign p2_sh    = p2_rnd >>> WORK_BITS;
    assign mid_next = MID_W'(COEF_C) + MID_W'(p2_sh);

    // Stage 8: p = round(t*mid / 2^29), negative clipped to zero
    assign p3_rnd = (P3_W + 1)'(p3_7_reg)
                  + (p3_7_reg[P3_W-1] ? (P3_W + 1)'(WORK_HALF - 1) : (P3_W + 1)'(WORK_HALF));
    assign p3_sh    = p3_rnd >>> WORK_BITS;
    assign pos_next = p3_sh[P3_W] ? '0 : POS_W'(p3_sh);

    // Output: rescale to the output format, saturate to 1.0, apply sign
    always_comb
    begin
        if (OUT_FRAC_BITS >= WORK_BITS)
            mag_wide = MAG_W'(pos8_reg) << SH_L;
        else
            mag_wide = (MAG_W'(pos8_reg) + (MAG_W'(1) << (SH_R - 1))) >> SH_R;

        if (sat_reg[7] || (mag_wide > MAG_W'(ONE_OUT)))
            mag = OUT_W'(ONE_OUT);
        else
            mag = OUT_W'(mag_wide);

        sine_next = neg_reg[7] ? (OUT_W'(0) - mag) : mag;
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[7:0], in_valid};
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sat_reg    <= {sat_reg[6:0], red.sat};
            neg_reg    <= {neg_reg[6:0], red.neg};

            // Stage 1: square
            sq1_reg    <= SQ_W'(red.t) * SQ_W'(red.t);
            t1_reg     <= red.t;

            // Stage 2
            t2_2_reg   <= T2_W'(sq_rnd >> WORK_BITS);
            t2s_reg    <= t1_reg;

            // Stage 3: A*t2
            pa3_reg    <= PA_W'($signed({1'b0, t2_2_reg})) * PA_W'(COEF_A);
            t2_3_reg   <= t2_2_reg;
            t3_reg     <= t2s_reg;

            // Stage 4
            inner4_reg <= inner_next;
            t2_4_reg   <= t2_3_reg;
            t4_reg     <= t3_reg;

            // Stage 5: t2*inner
            p2_5_reg   <= P2_W'($signed({1'b0, t2_4_reg})) * P2_W'(inner4_reg);
            t5_reg     <= t4_reg;

            // Stage 6
            mid6_reg   <= mid_next;
            t6_reg     <= t5_reg;

            // Stage 7: t*mid
            p3_7_reg   <= P3_W'($signed({1'b0, t6_reg})) * P3_W'(mid6_reg);

            // Stage 8
            pos8_reg   <= pos_next;

            // Output register
            sine_reg   <= sine_next;
        end
    end

    assign out_valid = v_reg[8];
    assign sine      = sine_reg;

endmodule
